[hdl/utf8_unicode_escaper_core_defines.svh]
// Assertion macros for the escaper's top-level RTL.
`ifndef UTF8_UNICODE_ESCAPER_CORE_DEFINES_SVH
`define UTF8_UNICODE_ESCAPER_CORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define U8ESC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only outside reset.
`define U8ESC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/u8esc_pkg.sv]
`default_nettype none
package u8esc_pkg;

	localparam int CODE_W = 21;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int IDX_W  = 4;

	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_LO_U = 8'h75;
	localparam logic [7:0] CH_UP_U = 8'h55;
	localparam logic [7:0] CTL_LO  = 8'h07;
	localparam logic [7:0] CTL_HI  = 8'h0D;
	localparam logic [7:0] PRT_LO  = 8'd32;
	localparam logic [7:0] PRT_HI  = 8'd126;
	localparam logic [CODE_W-1:0] BMP_MAX = 21'h00FFFF;

	typedef enum logic [1:0] {
		LEAD_NONE = 2'd0,
		LEAD_2    = 2'd1,
		LEAD_3    = 2'd2,
		LEAD_4    = 2'd3
	} lead_t;

	typedef enum logic [2:0] {
		JOB_ERR  = 3'd0,
		JOB_RAW  = 3'd1,
		JOB_CESC = 3'd2,
		JOB_U4   = 3'd3,
		JOB_U8   = 3'd4
	} job_kind_t;

	// One decoded code point (or error) waiting to be expanded.
	typedef struct packed {
		job_kind_t          kind;
		logic [CODE_W-1:0]  payload;
		logic               fin;
	} job_t;

	function automatic logic [IDX_W-1:0] job_last_idx(input job_kind_t kind);
		logic [IDX_W-1:0] r;
		unique case (kind)
			JOB_CESC: r = IDX_W'(1);
			JOB_U4:   r = IDX_W'(5);
			JOB_U8:   r = IDX_W'(9);
			default:  r = IDX_W'(0);
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ctl_letter(input logic [3:0] c);
		logic [7:0] r;
		unique case (c)
			4'h7:    r = 8'h61; // a
			4'h8:    r = 8'h62; // b
			4'h9:    r = 8'h74; // t
			4'hA:    r = 8'h6E; // n
			4'hB:    r = 8'h76; // v
			4'hC:    r = 8'h66; // f
			4'hD:    r = 8'h72; // r
			default: r = 8'h3F;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h57 + {4'h0, nib};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/u8esc_front.sv]
`default_nettype none
module u8esc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      byte_in,
	input  wire logic            fin_in,
	output u8esc_pkg::job_t      job,
	output logic                 push
);
	import u8esc_pkg::*;

	logic [CODE_W-1:0] acc_q, acc_n;
	logic [1:0]        pend_q, pend_n;
	lead_t             lead_q, lead_n;
	logic              errl_q, errl_n;

	logic              err, complete;
	logic [CODE_W-1:0] code_c, acc_new;
	logic [1:0]        pend_after;
	logic              first;

	always_comb begin
		acc_n      = acc_q;
		pend_n     = pend_q;
		lead_n     = lead_q;
		errl_n     = errl_q;
		err        = 1'b0;
		complete   = 1'b0;
		code_c     = '0;
		pend_after = pend_q;
		first      = (pend_q == 2'(lead_q));
		acc_new    = {acc_q[CODE_W-7:0], byte_in[5:0]};

		if (errl_q) begin
			// Bytes of a failed string are dropped until its final byte.
			if (fin_in) begin
				err = 1'b1;
			end
		end else if (pend_q == 2'd0) begin
			if (byte_in < 8'h80) begin
				code_c   = CODE_W'(byte_in);
				complete = 1'b1;
			end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
				acc_n      = CODE_W'(byte_in[4:0]);
				lead_n     = LEAD_2;
				pend_after = 2'd1;
			end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
				acc_n      = CODE_W'(byte_in[3:0]);
				lead_n     = LEAD_3;
				pend_after = 2'd2;
			end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
				acc_n      = CODE_W'(byte_in[2:0]);
				lead_n     = LEAD_4;
				pend_after = 2'd3;
			end else begin
				err = 1'b1;
			end
		end else begin
			if (byte_in[7:6] != 2'b10) begin
				err = 1'b1;
			end else if (first && lead_q == LEAD_3 &&
					(acc_new < 21'h20 || (acc_new >= 21'h360 && acc_new <= 21'h37F))) begin
				// Overlong three-byte form or a surrogate.
				err = 1'b1;
			end else if (first && lead_q == LEAD_4 &&
					(acc_new < 21'h10 || acc_new > 21'h10F)) begin
				err = 1'b1;
			end else begin
				pend_after = pend_q - 2'd1;
				acc_n      = acc_new;
				if (pend_after == 2'd0) begin
					code_c   = acc_new;
					complete = 1'b1;
				end
			end
		end

		// A string that ends inside a sequence is truncated.
		if (!errl_q && !err && pend_after != 2'd0 && fin_in) begin
			err = 1'b1;
		end

		pend_n = pend_after;
		if (err) begin
			complete = 1'b0;
			errl_n   = !fin_in;
		end
		if (err || complete) begin
			acc_n  = '0;
			pend_n = 2'd0;
			lead_n = LEAD_NONE;
		end
	end

	always_comb begin
		job.fin     = fin_in;
		job.kind    = JOB_ERR;
		job.payload = '0;
		if (complete) begin
			if (code_c >= CODE_W'(CTL_LO) && code_c <= CODE_W'(CTL_HI)) begin
				job.kind    = JOB_CESC;
				job.payload = CODE_W'(ctl_letter(code_c[3:0]));
			end else if (code_c == CODE_W'(CH_QUOT) || code_c == CODE_W'(CH_APOS) ||
					code_c == CODE_W'(CH_BSL)) begin
				job.kind    = JOB_CESC;
				job.payload = code_c;
			end else if (code_c >= CODE_W'(PRT_LO) && code_c <= CODE_W'(PRT_HI)) begin
				job.kind    = JOB_RAW;
				job.payload = code_c;
			end else if (code_c <= BMP_MAX) begin
				job.kind    = JOB_U4;
				job.payload = code_c;
			end else begin
				job.kind    = JOB_U8;
				job.payload = code_c;
			end
		end
		push = accept && (err || complete);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= 2'd0;
			lead_q <= LEAD_NONE;
			errl_q <= 1'b0;
		end else if (accept) begin
			acc_q  <= acc_n;
			pend_q <= pend_n;
			lead_q <= lead_n;
			errl_q <= errl_n;
		end
	end

endmodule
`default_nettype wire

[hdl/u8esc_queue.sv]
`default_nettype none
module u8esc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u8esc_pkg::job_t wr_job,
	input  wire logic            pop,
	output u8esc_pkg::job_t      rd_job,
	output logic                 full,
	output logic                 empty
);
	import u8esc_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/u8esc_back.sv]
`default_nettype none
module u8esc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire u8esc_pkg::job_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic                 out_bad,
	output logic                 out_done
);
	import u8esc_pkg::*;

	job_t             job_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;

	logic             take, last;
	logic [IDX_W-1:0] nsel_w;
	logic [31:0]      padded;
	logic [3:0]       nib;

	assign last      = (idx_q == job_last_idx(job_q.kind));
	assign take      = busy_q && out_ready;
	assign pop       = head_valid && (!busy_q || (take && last));
	assign out_valid = busy_q;
	assign out_last  = last;
	assign out_bad   = (job_q.kind == JOB_ERR);
	assign out_done  = last && job_q.fin;

	// Hex digits are sent most significant first, after the two-byte prefix.
	assign nsel_w = (job_q.kind == JOB_U4) ? IDX_W'(5) - idx_q : IDX_W'(9) - idx_q;
	assign padded = {{(32 - CODE_W){1'b0}}, job_q.payload};
	assign nib    = padded[nsel_w[2:0] * 4 +: 4];

	always_comb begin
		unique case (job_q.kind)
			JOB_RAW: out_byte = job_q.payload[7:0];
			JOB_CESC: out_byte = (idx_q == '0) ? CH_BSL : job_q.payload[7:0];
			JOB_U4: begin
				if (idx_q == '0) begin
					out_byte = CH_BSL;
				end else if (idx_q == IDX_W'(1)) begin
					out_byte = CH_LO_U;
				end else begin
					out_byte = hex_ascii(nib);
				end
			end
			JOB_U8: begin
				if (idx_q == '0) begin
					out_byte = CH_BSL;
				end else if (idx_q == IDX_W'(1)) begin
					out_byte = CH_UP_U;
				end else begin
					out_byte = hex_ascii(nib);
				end
			end
			default: out_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/utf8_unicode_escaper_core.sv]
// A job is queued when its last UTF-8 byte is accepted; the expander then registers it.
// Throughput: one byte per cycle while m_tready is high and each code point yields one byte.
// A code point expanding to n bytes (2, 6 or 10) holds the output stage until all are taken;
// a two-entry job queue between decoder and expander absorbs the difference.
// Reset (arst_n low, asynchronous) clears the decoder, error latch, queue and expander.
`default_nettype none
`include "utf8_unicode_escaper_core_defines.svh"
module utf8_unicode_escaper_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] byte_in
	input  wire logic       s_tlast,   // string_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] byte_out
	output logic            m_tlast,   // run_last
	output logic [1:0]      m_tuser    // [0] bad_utf8, [1] string_done
);
	import u8esc_pkg::*;

	job_t q_wr, q_rd;
	logic q_push, q_pop, q_full, q_empty;
	logic accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	u8esc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (s_tdata),
		.fin_in  (s_tlast),
		.job     (q_wr),
		.push    (q_push)
	);

	u8esc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (q_wr),
		.pop    (q_pop),
		.rd_job (q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	u8esc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_bad    (m_tuser[0]),
		.out_done   (m_tuser[1])
	);

	`U8ESC_ASSERT_NOW(a_err_is_last, m_tvalid && m_tuser[0], m_tlast, "error request not last")
	`U8ESC_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser[1], m_tlast, "string end mid-run")
	`U8ESC_ASSERT_NOW(a_no_overflow, q_push, !q_full, "job queue overflow")
	`U8ESC_ASSERT_NEXT(a_pop_loads, q_pop, m_tvalid, "expander idle after pop")

endmodule
`default_nettype wire
